[rtl/dcma_pkg.sv]
package dcma_pkg;

    localparam int DEFAULT_DEPTH = 10;
    localparam int SAMPLE_W      = 16;
    localparam int AVG_W         = 20;
    localparam int COUNT_W       = 4;
    localparam int COUNT_SAT     = 15;
    localparam int FRAC_W        = 4;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 48;

    typedef enum logic [0:0] {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

[rtl/dcma_front.sv]
module dcma_front
    import dcma_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_DEPTH,
    localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1),
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_DEPTH) + 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_ok,
    input  logic signed [SAMPLE_W-1:0] in_temp,
    input  logic signed [SAMPLE_W-1:0] in_hum,
    output logic                       job_valid,
    input  logic                       job_ready,
    output logic signed [SUM_W-1:0]    job_t_sum,
    output logic signed [SUM_W-1:0]    job_h_sum,
    output logic [CNT_W-1:0]           job_count,
    output logic                       job_err
);

    front_state_t state_reg, state_next;

    logic                       ok_reg;
    logic signed [SAMPLE_W-1:0] t_reg;
    logic signed [SAMPLE_W-1:0] h_reg;

    logic [IDX_W-1:0]           idx_reg;
    logic                       full_reg;
    logic signed [SUM_W-1:0]    t_sum_reg;
    logic signed [SUM_W-1:0]    h_sum_reg;

    logic signed [SAMPLE_W-1:0] t_mem [SAMPLE_DEPTH];
    logic signed [SAMPLE_W-1:0] h_mem [SAMPLE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_t_reg;
    logic signed [SAMPLE_W-1:0] rd_h_reg;

    logic                       last_slot;
    logic signed [SAMPLE_W-1:0] old_t;
    logic signed [SAMPLE_W-1:0] old_h;
    logic signed [SUM_W-1:0]    t_sum_upd;
    logic signed [SUM_W-1:0]    h_sum_upd;
    logic [IDX_W-1:0]           idx_upd;
    logic                       full_upd;
    logic                       commit;

    assign in_ready = (state_reg == F_IDLE);
    assign commit   = (state_reg == F_UPDATE) && job_ready;

    // The old entry is read every cycle at the write index, so it is ready in the
    // cycle after the transfer and stays put while the queue is full.
    always_ff @(posedge clk)
    begin
        if (commit && ok_reg)
        begin
            t_mem[idx_reg] <= t_reg;
            h_mem[idx_reg] <= h_reg;
        end
        rd_t_reg <= t_mem[idx_reg];
        rd_h_reg <= h_mem[idx_reg];
    end

    always_comb
    begin
        last_slot = (idx_reg == IDX_W'(SAMPLE_DEPTH - 1));
        old_t     = full_reg ? rd_t_reg : '0;
        old_h     = full_reg ? rd_h_reg : '0;
        t_sum_upd = t_sum_reg - SUM_W'(old_t) + SUM_W'(t_reg);
        h_sum_upd = h_sum_reg - SUM_W'(old_h) + SUM_W'(h_reg);
        idx_upd   = last_slot ? '0 : idx_reg + 1'b1;
        full_upd  = full_reg | last_slot;
    end

    always_comb
    begin
        state_next = state_reg;
        job_valid  = 1'b0;
        job_t_sum  = t_sum_reg;
        job_h_sum  = h_sum_reg;
        job_count  = full_reg ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(idx_reg);
        job_err    = 1'b1;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE:
            begin
                job_valid = 1'b1;
                if (ok_reg)
                begin
                    job_t_sum = t_sum_upd;
                    job_h_sum = h_sum_upd;
                    job_count = full_upd ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(idx_upd);
                    job_err   = 1'b0;
                end
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ok_reg <= in_ok;
            t_reg  <= in_temp;
            h_reg  <= in_hum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            full_reg  <= 1'b0;
            t_sum_reg <= '0;
            h_sum_reg <= '0;
        end
        else if (commit)
        begin
            if (ok_reg)
            begin
                idx_reg   <= idx_upd;
                full_reg  <= full_upd;
                t_sum_reg <= t_sum_upd;
                h_sum_reg <= h_sum_upd;
            end
        end
    end

endmodule

[rtl/dcma_queue.sv]
module dcma_queue
    import dcma_pkg::*;
#(
    parameter int WIDTH = IN_TDATA_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/dcma_back.sv]
module dcma_back
    import dcma_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_DEPTH,
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1),
    localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLE_DEPTH) + 1,
    localparam int DW     = SUM_W + FRAC_W,
    localparam int STEP_W = $clog2(DW + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  logic signed [SUM_W-1:0]  job_t_sum,
    input  logic signed [SUM_W-1:0]  job_h_sum,
    input  logic [CNT_W-1:0]         job_count,
    input  logic                     job_err,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [AVG_W-1:0]  out_t_avg,
    output logic signed [AVG_W-1:0]  out_h_avg,
    output logic                     out_err,
    output logic [COUNT_W-1:0]       out_count
);

    localparam int SAT_W = CNT_W + COUNT_W;

    back_state_t state_reg, state_next;

    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     t_q_reg;
    logic [DW-1:0]     h_q_reg;
    logic [CNT_W-1:0]  t_rem_reg;
    logic [CNT_W-1:0]  h_rem_reg;
    logic              t_neg_reg;
    logic              h_neg_reg;
    logic [CNT_W-1:0]  div_reg;
    logic              err_reg;

    logic [SUM_W-1:0]  t_abs;
    logic [SUM_W-1:0]  h_abs;
    logic [CNT_W:0]    t_sh;
    logic [CNT_W:0]    h_sh;
    logic              t_ge;
    logic              h_ge;
    logic [CNT_W:0]    t_diff;
    logic [CNT_W:0]    h_diff;
    logic [DW-1:0]     t_res;
    logic [DW-1:0]     h_res;
    logic [SAT_W-1:0]  count_wide;

    assign t_abs = job_t_sum[SUM_W-1] ? SUM_W'(-job_t_sum) : SUM_W'(job_t_sum);
    assign h_abs = job_h_sum[SUM_W-1] ? SUM_W'(-job_h_sum) : SUM_W'(job_h_sum);

    // Restoring division, one quotient bit per cycle on both channels.
    always_comb
    begin
        t_sh   = {t_rem_reg, t_q_reg[DW-1]};
        h_sh   = {h_rem_reg, h_q_reg[DW-1]};
        t_ge   = (t_sh >= {1'b0, div_reg});
        h_ge   = (h_sh >= {1'b0, div_reg});
        t_diff = t_sh - {1'b0, div_reg};
        h_diff = h_sh - {1'b0, div_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(DW - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            t_q_reg   <= {t_abs, FRAC_W'(0)};
            h_q_reg   <= {h_abs, FRAC_W'(0)};
            t_rem_reg <= '0;
            h_rem_reg <= '0;
            t_neg_reg <= job_t_sum[SUM_W-1];
            h_neg_reg <= job_h_sum[SUM_W-1];
            div_reg   <= job_count;
            err_reg   <= job_err;
            step_reg  <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            t_q_reg   <= {t_q_reg[DW-2:0], t_ge};
            h_q_reg   <= {h_q_reg[DW-2:0], h_ge};
            t_rem_reg <= t_ge ? t_diff[CNT_W-1:0] : t_sh[CNT_W-1:0];
            h_rem_reg <= h_ge ? h_diff[CNT_W-1:0] : h_sh[CNT_W-1:0];
            step_reg  <= step_reg + 1'b1;
        end
    end

    // An empty ring has a zero divisor; its averages are forced to zero.
    always_comb
    begin
        t_res      = t_neg_reg ? (~t_q_reg + 1'b1) : t_q_reg;
        h_res      = h_neg_reg ? (~h_q_reg + 1'b1) : h_q_reg;
        out_t_avg  = (div_reg == '0) ? '0 : t_res[AVG_W-1:0];
        out_h_avg  = (div_reg == '0) ? '0 : h_res[AVG_W-1:0];
        out_err    = err_reg;
        count_wide = SAT_W'(div_reg);
        out_count  = (count_wide > SAT_W'(COUNT_SAT)) ? COUNT_W'(COUNT_SAT)
                                                       : count_wide[COUNT_W-1:0];
    end

endmodule

[rtl/dual_channel_moving_average.sv]
// Channel   Bus      tdata (low bit up)                                   tuser
// input     s_axis   temperature_raw[15:0], humidity_raw[31:16]           read_ok
// output    m_axis   temperature_average[19:0], humidity_average[39:20],  error_flag
//                    sample_count[43:40], zero fill[47:44]
//
// The front takes a reading in F_IDLE and updates the rings and sums in F_UPDATE,
// so it takes no new reading until that update is pushed into the two-entry queue.
// The back loads a job in B_IDLE, runs the restoring divider in B_DIV over
// DW = SUM_W + 4 quotient bits (25 for a depth of 10) and presents the result in
// B_OUT; it takes no new job until the result has been taken.
// Reset clears the index, the full flag, both sums and all control; the ring
// memories are not cleared, since an entry is used only after it is written.
// A stalled output only holds the back; the front keeps taking items until the
// queue fills.
module dual_channel_moving_average
    import dcma_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // temperature_raw, humidity_raw
    input  logic                   s_axis_tuser,   // read_ok
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // temperature_average,
                                                   // humidity_average, sample_count
    output logic                   m_axis_tuser    // error_flag
);

    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_DEPTH) + 1;
    localparam int JOB_W = 2 * SUM_W + CNT_W + 1;

    logic                    f_valid;
    logic                    f_ready;
    logic signed [SUM_W-1:0] f_t_sum;
    logic signed [SUM_W-1:0] f_h_sum;
    logic [CNT_W-1:0]        f_count;
    logic                    f_err;

    logic                    b_valid;
    logic                    b_ready;
    logic [JOB_W-1:0]        b_data;

    logic signed [AVG_W-1:0] t_avg;
    logic signed [AVG_W-1:0] h_avg;
    logic [COUNT_W-1:0]      count;

    dcma_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_ok     (s_axis_tuser),
        .in_temp   (s_axis_tdata[SAMPLE_W-1:0]),
        .in_hum    (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_t_sum (f_t_sum),
        .job_h_sum (f_h_sum),
        .job_count (f_count),
        .job_err   (f_err)
    );

    dcma_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_err, f_count, f_h_sum, f_t_sum}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    dcma_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job_t_sum (b_data[SUM_W-1:0]),
        .job_h_sum (b_data[2*SUM_W-1:SUM_W]),
        .job_count (b_data[2*SUM_W+CNT_W-1:2*SUM_W]),
        .job_err   (b_data[JOB_W-1]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_t_avg (t_avg),
        .out_h_avg (h_avg),
        .out_err   (m_axis_tuser),
        .out_count (count)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - 2 * AVG_W - COUNT_W)'(0), count, h_avg, t_avg};

endmodule

[rtl/dcma_checker.sv]
module dcma_checker
    import dcma_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEFAULT_DEPTH
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    localparam int MAX_CNT = (SAMPLE_DEPTH > COUNT_SAT) ? COUNT_SAT : SAMPLE_DEPTH;

    logic [COUNT_W-1:0] count;
    logic [AVG_W-1:0]   t_avg;
    logic [AVG_W-1:0]   h_avg;

    assign t_avg = m_axis_tdata[AVG_W-1:0];
    assign h_avg = m_axis_tdata[2*AVG_W-1:AVG_W];
    assign count = m_axis_tdata[2*AVG_W+COUNT_W-1:2*AVG_W];

    // Reset clears the control asynchronously, so the output must be quiet in the
    // cycle after any cycle in which reset is sampled low.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count <= COUNT_W'(MAX_CNT))
        else $error("sample count beyond ring depth");

    a_good_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> count != '0)
        else $error("good reading reported with an empty ring");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && count == '0 |-> t_avg == '0 && h_avg == '0)
        else $error("empty ring reported a nonzero average");

endmodule

bind dual_channel_moving_average dcma_checker #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
) u_dcma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[dv/tb_dual_channel_moving_average.sv]
module tb_dual_channel_moving_average;
    import dcma_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    typedef struct {
        bit                          ok;
        logic signed [SAMPLE_W-1:0]  temp;
        logic signed [SAMPLE_W-1:0]  hum;
        int unsigned                 idle;
        bit                          drain;
    } reading_t;

    typedef struct {
        logic [AVG_W-1:0]   t_avg;
        logic [AVG_W-1:0]   h_avg;
        bit                 err;
        logic [COUNT_W-1:0] cnt;
    } avg_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    dual_channel_moving_average #(
        .SAMPLE_DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    reading_t    reading_q [$];
    avg_result_t avg_expect_q [$];
    reading_t    in_flight;

    // Predicted block state.
    logic signed [SAMPLE_W-1:0] temp_hist [DEPTH];
    logic signed [SAMPLE_W-1:0] hum_hist [DEPTH];
    int  wr_slot = 0;
    bit  hist_full = 1'b0;
    bit  last_failed = 1'b0;
    int  temp_total = 0;
    int  hum_total = 0;

    int  errors = 0;
    int  good_reads = 0;
    int  failed_reads = 0;
    int  results_seen = 0;
    int  ring_wraps = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    int unsigned idle_waited = 0;
    int unsigned stall_left = 0;

    function automatic logic [AVG_W-1:0] q4_mean(input int total, input int n);
        longint q;
        if (n == 0)
            return '0;
        // Signed division in SystemVerilog truncates toward zero.
        q = (longint'(total) * 16) / n;
        return q[AVG_W-1:0];
    endfunction

    function automatic avg_result_t advance_rings(input reading_t r);
        avg_result_t res;
        int n;
        if (r.ok) begin
            if (hist_full) begin
                temp_total -= temp_hist[wr_slot];
                hum_total  -= hum_hist[wr_slot];
            end
            temp_hist[wr_slot] = r.temp;
            hum_hist[wr_slot]  = r.hum;
            temp_total += r.temp;
            hum_total  += r.hum;
            if (wr_slot == DEPTH - 1) begin
                hist_full = 1'b1;
                ring_wraps++;
            end
            wr_slot = (wr_slot + 1) % DEPTH;
            last_failed = 1'b0;
        end
        else begin
            last_failed = 1'b1;
        end
        n = hist_full ? DEPTH : wr_slot;
        res.t_avg = q4_mean(temp_total, n);
        res.h_avg = q4_mean(hum_total, n);
        res.err   = last_failed;
        res.cnt   = COUNT_W'((n > COUNT_SAT) ? COUNT_SAT : n);
        return res;
    endfunction

    task automatic add_reading(input bit ok, input logic [SAMPLE_W-1:0] t,
                               input logic [SAMPLE_W-1:0] h, input bit drain);
        reading_t r;
        if ($urandom_range(0, 29) == 0)
            tx_steady = !tx_steady;
        r.ok    = ok;
        r.temp  = t;
        r.hum   = h;
        r.idle  = tx_steady ? 0 : $urandom_range(0, 4);
        r.drain = drain;
        reading_q.push_back(r);
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Sender: a new item goes out once the previous transfer is done and its idle
    // count has elapsed; a draining item also waits for all outstanding averages.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            idle_waited = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                avg_expect_q.push_back(advance_rings(in_flight));
                if (in_flight.ok)
                    good_reads++;
                else
                    failed_reads++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (reading_q.size() != 0 && idle_waited >= reading_q[0].idle
                    && !(reading_q[0].drain && avg_expect_q.size() != 0)) begin
                    in_flight = reading_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {in_flight.hum, in_flight.temp};
                    s_axis_tuser  <= in_flight.ok;
                    idle_waited = 0;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                    if (reading_q.size() != 0 && idle_waited < reading_q[0].idle)
                        idle_waited++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        avg_result_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (avg_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else begin
                    want = avg_expect_q.pop_front();
                    if (m_axis_tdata[AVG_W-1:0] !== want.t_avg)
                        report_field("temperature_average", $signed(want.t_avg),
                                     $signed(m_axis_tdata[AVG_W-1:0]));
                    if (m_axis_tdata[2*AVG_W-1:AVG_W] !== want.h_avg)
                        report_field("humidity_average", $signed(want.h_avg),
                                     $signed(m_axis_tdata[2*AVG_W-1:AVG_W]));
                    if (m_axis_tuser !== want.err)
                        report_field("error_flag", want.err, m_axis_tuser);
                    if (m_axis_tdata[2*AVG_W+COUNT_W-1:2*AVG_W] !== want.cnt)
                        report_field("sample_count", want.cnt,
                                     m_axis_tdata[2*AVG_W+COUNT_W-1:2*AVG_W]);
                    if (m_axis_tdata[OUT_TDATA_W-1:2*AVG_W+COUNT_W] !== '0)
                        report_field("tdata fill", 0,
                                     m_axis_tdata[OUT_TDATA_W-1:2*AVG_W+COUNT_W]);
                end
                if ($urandom_range(0, 24) == 0)
                    rx_steady = !rx_steady;
                stall_left = rx_steady ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned kind;
        int st;
        int sh;

        // Failed reading on an empty ring, then fill with the extremes, overwrite
        // every slot with the opposite extremes, and finish with small values.
        add_reading(1'b0, 16'h5A5A, 16'hA5A5, 1'b0);
        for (int i = 0; i < DEPTH; i++) begin
            add_reading(1'b1, 16'sh7FFF, 16'sh8000, 1'b0);
            if (i == 4)
                add_reading(1'b0, 16'hFFFF, 16'h0000, 1'b0);
        end
        for (int i = 0; i < DEPTH; i++)
            add_reading(1'b1, 16'sh8000, 16'sh7FFF, 1'b0);
        add_reading(1'b0, 16'h0000, 16'hFFFF, 1'b0);
        add_reading(1'b0, 16'h1234, 16'hEDCB, 1'b0);
        add_reading(1'b1, 16'hFFFF, 16'h0001, 1'b0);

        for (int i = 0; i < 550; i++) begin
            kind = $urandom_range(0, 9);
            st = int'($urandom_range(0, 16)) - 8;
            sh = int'($urandom_range(0, 16)) - 8;
            case (kind)
                0, 1: add_reading(1'b0, 16'($urandom), 16'($urandom), (i % 120) == 0);
                2:    add_reading(1'b1, $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                  $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                                  (i % 120) == 0);
                3, 4: add_reading(1'b1, st[SAMPLE_W-1:0], sh[SAMPLE_W-1:0], (i % 120) == 0);
                default:
                      add_reading(1'b1, 16'($urandom), 16'($urandom), (i % 120) == 0);
            endcase
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (reading_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (avg_expect_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (avg_expect_q.size() != 0) begin
            errors++;
            $display("%0t: %0d averages never arrived", $time, avg_expect_q.size());
        end
        $display("Summary: %0d readings sent (%0d good, %0d failed), %0d results checked,",
                 good_reads + failed_reads, good_reads, failed_reads, results_seen);
        $display("         the sample ring wrapped %0d times; %0d errors.", ring_wraps, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout at %0t with %0d results outstanding", $time, avg_expect_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/dcma_pkg.sv
rtl/dcma_front.sv
rtl/dcma_queue.sv
rtl/dcma_back.sv
rtl/dual_channel_moving_average.sv
rtl/dcma_checker.sv
dv/tb_dual_channel_moving_average.sv
